// ===== rtl/sdspi_pkg.sv =====
// Package for the SD card SPI-mode start-up sequencer.
// Holds shared types, status and register codes, and the command byte table.
// No dependencies.
package sdspi_pkg;

  // Number of 0xFF clock-out bytes sent with select released.
  localparam int unsigned DummyBytesDefault = 10;

  // Configuration register indexes and reset values.
  localparam logic CfgPollLimit  = 1'b0;
  localparam logic CfgRetryLimit = 1'b1;
  localparam logic [7:0] PollLimitReset  = 8'd99;
  localparam logic [7:0] RetryLimitReset = 8'd101;

  // Final status codes.
  localparam logic [2:0] StatusOk            = 3'd0;
  localparam logic [2:0] StatusNoCard        = 3'd1;
  localparam logic [2:0] StatusCmd8Timeout   = 3'd2;
  localparam logic [2:0] StatusVoltage       = 3'd3;
  localparam logic [2:0] StatusAcmd41Timeout = 3'd4;

  // Bytes on the wire.
  localparam logic [7:0] IdleByte    = 8'hFF;
  localparam logic [7:0] R1IdleState = 8'h01;
  localparam logic [7:0] R1Ready     = 8'h00;
  localparam int unsigned CmdLen     = 6;
  localparam int unsigned OcrBytes   = 3;
  localparam int unsigned Vdd33Bit   = 4;

  // Commands of the start-up sequence.
  typedef enum logic [2:0] {
    CmdGoIdle,
    CmdSendIfCond,
    CmdReadOcr,
    CmdAppCmd,
    CmdSdSendOpCond
  } cmd_e;

  // One input request.
  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
    logic       card_present;
  } item_t;

  // One result request.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       select_asserted;
    logic       finished;
    logic [2:0] status;
  } result_t;

  // Configuration limits handed to the sequencer.
  typedef struct packed {
    logic [7:0] poll_limit;
    logic [7:0] retry_limit;
  } limits_t;

  // Byte idx of the six-byte frame of command c.
  function automatic logic [7:0] cmd_byte(cmd_e c, logic [2:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      3'd0: begin
        case (c)
          CmdGoIdle:       b = 8'h40;
          CmdSendIfCond:   b = 8'h48;
          CmdReadOcr:      b = 8'h7A;
          CmdAppCmd:       b = 8'h77;
          CmdSdSendOpCond: b = 8'h69;
          default:         b = 8'h00;
        endcase
      end
      3'd1: b = (c == CmdSdSendOpCond) ? 8'h40 : 8'h00;
      3'd3: b = (c == CmdSendIfCond) ? 8'h01 : 8'h00;
      3'd4: b = (c == CmdSendIfCond) ? 8'hAA : 8'h00;
      3'd5: begin
        case (c)
          CmdSendIfCond: b = 8'h87;
          CmdAppCmd:     b = 8'h7A;
          default:       b = 8'h95;
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/sdspi_fsm.sv =====
// Sequencer state machine for SD card SPI-mode start-up.
// Computes the result of one request from the current state; steps on step_i.
// Depends on sdspi_pkg.
module sdspi_fsm
  import sdspi_pkg::*;
#(
  parameter int unsigned DummyBytes = DummyBytesDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  limits_t limits_i,
  output result_t result_o
);

  typedef enum logic [2:0] {
    PhIdle,
    PhDummy,
    PhSend,
    PhResp,
    PhData,
    PhDone
  } phase_e;

  phase_e     phase_q, phase_d;
  cmd_e       cmd_q, cmd_d;
  logic [3:0] byte_idx_q, byte_idx_d;
  logic [7:0] poll_q, poll_d;
  logic [7:0] retry_q, retry_d;
  logic       ocr_ok_q, ocr_ok_d;
  logic [2:0] status_q, status_d;

  logic [7:0] poll_lim, retry_lim;
  logic [3:0] byte_inc;
  logic [7:0] retry_inc;
  logic       start_en, finish_en, timed_out;
  cmd_e       start_cmd;
  logic [2:0] finish_st;

  // A zero limit behaves as a limit of one.
  assign poll_lim  = (limits_i.poll_limit == 8'd0) ? 8'd1 : limits_i.poll_limit;
  assign retry_lim = (limits_i.retry_limit == 8'd0) ? 8'd1 : limits_i.retry_limit;
  assign byte_inc  = byte_idx_q + 4'd1;
  assign retry_inc = retry_q + 8'd1;
  assign timed_out = (item_i.rx_byte == IdleByte);

  // Next state and result for the request at the input.
  always_comb begin
    phase_d    = phase_q;
    cmd_d      = cmd_q;
    byte_idx_d = byte_idx_q;
    poll_d     = poll_q;
    retry_d    = retry_q;
    ocr_ok_d   = ocr_ok_q;
    status_d   = status_q;
    result_o   = '0;
    start_en   = 1'b0;
    start_cmd  = CmdGoIdle;
    finish_en  = 1'b0;
    finish_st  = StatusOk;

    if (!item_i.kind) begin
      // Start request: restart the whole sequence.
      byte_idx_d = '0;
      poll_d     = '0;
      retry_d    = '0;
      ocr_ok_d   = 1'b0;
      if (!item_i.card_present) begin
        finish_en = 1'b1;
        finish_st = StatusNoCard;
      end else begin
        phase_d  = PhDummy;
        poll_d   = 8'd1;
        result_o.tx_byte  = IdleByte;
        result_o.tx_valid = 1'b1;
      end
    end else begin
      unique case (phase_q)
        PhIdle: ;
        PhDummy: begin
          if (poll_q < 8'(DummyBytes)) begin
            poll_d = poll_q + 8'd1;
            result_o.tx_byte  = IdleByte;
            result_o.tx_valid = 1'b1;
          end else begin
            start_en  = 1'b1;
            start_cmd = CmdGoIdle;
          end
        end
        PhSend: begin
          byte_idx_d = byte_inc;
          result_o.tx_valid        = 1'b1;
          result_o.select_asserted = 1'b1;
          if (byte_inc < 4'(CmdLen)) begin
            result_o.tx_byte = cmd_byte(cmd_q, byte_inc[2:0]);
          end else begin
            phase_d = PhResp;
            poll_d  = 8'd1;
            result_o.tx_byte = IdleByte;
          end
        end
        PhResp: begin
          if (!timed_out || poll_q >= poll_lim) begin
            // A response byte arrived, or the poll limit ran out.
            unique case (cmd_q)
              CmdGoIdle: begin
                retry_d   = '0;
                start_en  = 1'b1;
                start_cmd = CmdSendIfCond;
              end
              CmdSendIfCond: begin
                if (item_i.rx_byte == R1IdleState) begin
                  start_en  = 1'b1;
                  start_cmd = CmdReadOcr;
                end else begin
                  retry_d = retry_inc;
                  if (retry_inc >= retry_lim) begin
                    finish_en = 1'b1;
                    finish_st = StatusCmd8Timeout;
                  end else begin
                    start_en  = 1'b1;
                    start_cmd = CmdSendIfCond;
                  end
                end
              end
              CmdReadOcr: begin
                if (timed_out) begin
                  finish_en = 1'b1;
                  finish_st = StatusVoltage;
                end else begin
                  phase_d    = PhData;
                  byte_idx_d = '0;
                  result_o.tx_byte         = IdleByte;
                  result_o.tx_valid        = 1'b1;
                  result_o.select_asserted = 1'b1;
                end
              end
              CmdAppCmd: begin
                start_en  = 1'b1;
                start_cmd = CmdSdSendOpCond;
              end
              CmdSdSendOpCond: begin
                if (item_i.rx_byte == R1Ready) begin
                  finish_en = 1'b1;
                  finish_st = StatusOk;
                end else begin
                  retry_d = retry_inc;
                  if (retry_inc >= retry_lim) begin
                    finish_en = 1'b1;
                    finish_st = StatusAcmd41Timeout;
                  end else begin
                    start_en  = 1'b1;
                    start_cmd = CmdAppCmd;
                  end
                end
              end
              default: ;
            endcase
          end else begin
            poll_d = poll_q + 8'd1;
            result_o.tx_byte         = IdleByte;
            result_o.tx_valid        = 1'b1;
            result_o.select_asserted = 1'b1;
          end
        end
        PhData: begin
          // The second OCR byte carries the 3.3 V window bit.
          if (byte_idx_q == 4'd1) begin
            ocr_ok_d = item_i.rx_byte[Vdd33Bit];
          end
          byte_idx_d = byte_inc;
          if (byte_inc < 4'(OcrBytes)) begin
            result_o.tx_byte         = IdleByte;
            result_o.tx_valid        = 1'b1;
            result_o.select_asserted = 1'b1;
          end else if (!ocr_ok_q) begin
            finish_en = 1'b1;
            finish_st = StatusVoltage;
          end else begin
            retry_d   = '0;
            start_en  = 1'b1;
            start_cmd = CmdAppCmd;
          end
        end
        PhDone: begin
          result_o.finished = 1'b1;
          result_o.status   = status_q;
        end
        default: ;
      endcase
    end

    // Launch a command frame with its first byte.
    if (start_en) begin
      phase_d    = PhSend;
      cmd_d      = start_cmd;
      byte_idx_d = '0;
      result_o.tx_byte         = cmd_byte(start_cmd, 3'd0);
      result_o.tx_valid        = 1'b1;
      result_o.select_asserted = 1'b1;
    end

    // End the sequence with a final status.
    if (finish_en) begin
      phase_d  = PhDone;
      status_d = finish_st;
      result_o.finished = 1'b1;
      result_o.status   = finish_st;
    end
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      cmd_q      <= CmdGoIdle;
      byte_idx_q <= '0;
      poll_q     <= '0;
      retry_q    <= '0;
      ocr_ok_q   <= 1'b0;
      status_q   <= StatusOk;
    end else if (step_i) begin
      phase_q    <= phase_d;
      cmd_q      <= cmd_d;
      byte_idx_q <= byte_idx_d;
      poll_q     <= poll_d;
      retry_q    <= retry_d;
      ocr_ok_q   <= ocr_ok_d;
      status_q   <= status_d;
    end
  end

endmodule

// ===== rtl/sd_card_spi_init_sequencer.sv =====
// SD card SPI-mode start-up sequencer, top level.
// A request accepted into the input register moves on to the result register when that
// register is free or drains; its result is then offered. One request per cycle while
// the result stream does not stall, set by the combinational next-state logic.
// Reset clears the sequencer to idle and loads the limits with 99 and 101.
// Depends on sdspi_pkg and sdspi_fsm.
module sd_card_spi_init_sequencer
  import sdspi_pkg::*;
#(
  parameter int unsigned DummyBytes = DummyBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] rx_byte, [8] card_present, rest zero
  input  logic [0:0]  s_axis_tuser,  // [0] kind
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] tx_byte, [8] tx_valid, [9] select_asserted, [10] finished,
  // [13:11] status, rest zero
  output logic [15:0] m_axis_tdata
);

  logic    in_valid_q;
  item_t   in_item_q;
  logic    out_valid_q;
  result_t res_q;
  result_t res_d;
  limits_t limits_q;
  logic    advance;

  // The input register moves on when the result register is free or drains.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.poll_limit  <= PollLimitReset;
      limits_q.retry_limit <= RetryLimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPollLimit:  limits_q.poll_limit  <= cfg_wdata_i;
        CfgRetryLimit: limits_q.retry_limit <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Valid flags of the input and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q.kind         <= s_axis_tuser[0];
      in_item_q.rx_byte      <= s_axis_tdata[7:0];
      in_item_q.card_present <= s_axis_tdata[8];
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  // Sequencer steps once for each request that moves to the result register.
  sdspi_fsm #(
    .DummyBytes(DummyBytes)
  ) u_fsm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .item_i  (in_item_q),
    .limits_i(limits_q),
    .result_o(res_d)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, res_q.status, res_q.finished, res_q.select_asserted,
                          res_q.tx_valid, res_q.tx_byte};

  // The input side stalls only while a request waits in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q)
    else $error("input stalled with an empty input register");

  // A request that moves on always shows up as a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced request did not reach the result register");

  // With no exchange requested, the byte and the select stay low.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.tx_valid) |-> (res_q.tx_byte == 8'h00 && !res_q.select_asserted))
    else $error("idle result carries a byte or select");

  // A finished sequence requests no exchange, and status is zero until finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((res_q.finished && !res_q.tx_valid) ||
                     (!res_q.finished && res_q.status == StatusOk)))
    else $error("finished flag and status disagree");

endmodule

// ===== dv/sd_card_spi_init_sequencer_test.sv =====
// Self-checking testbench for the SD card SPI-mode start-up sequencer.
// It runs a card model against a cycle-free predictor and checks every exchange request.
// Depends on sdspi_pkg and the sd_card_spi_init_sequencer RTL.
module sd_card_spi_init_sequencer_test;
  import sdspi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemTarget   = 1950;
  localparam int SettleCycles = 6;
  localparam int HoldCycles   = 80;
  localparam int StallLimit   = 1000;

  // Sequencer steps as tracked by the predictor.
  typedef enum logic [2:0] {
    SeqIdle,
    SeqDummy,
    SeqCmd,
    SeqPoll,
    SeqOcr,
    SeqDone
  } seq_phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = CfgPollLimit;
  logic [7:0]  cfg_wdata_i = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = 16'h0000;  // [7:0] rx_byte, [8] card_present, rest zero
  logic [0:0]  s_axis_tuser = 1'b0;      // [0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [7:0] tx_byte, [8] tx_valid, [9] select_asserted, [10] finished,
  // [13:11] status, rest zero
  logic [15:0] m_axis_tdata;

  // Predictor state and its copy of the limits.
  seq_phase_e  seq_phase;
  cmd_e        cur_cmd;
  int          byte_idx;
  int          poll_cnt;
  int          retry_cnt;
  logic [7:0]  last_r1;
  logic [7:0]  ocr_byte;
  logic [2:0]  final_status;
  logic [7:0]  poll_limit;
  logic [7:0]  retry_limit;

  result_t     pending_exchanges[$];
  int          mismatch_count = 0;
  int          items_sent = 0;
  int          quiet_cycles = 0;
  logic        idle_en = 1'b1;
  int          hold_seq = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          stall_left = 0;

  sd_card_spi_init_sequencer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // A limit register of zero acts as one.
  function automatic int floor_one(logic [7:0] v);
    return (v == 8'd0) ? 1 : int'(v);
  endfunction

  // Byte idx of the six-byte frame of command c.
  function automatic logic [7:0] frame_byte(cmd_e c, int idx);
    logic [47:0] frame;
    case (c)
      CmdGoIdle:     frame = 48'h40_00_00_00_00_95;
      CmdSendIfCond: frame = 48'h48_00_00_01_AA_87;
      CmdReadOcr:    frame = 48'h7A_00_00_00_00_95;
      CmdAppCmd:     frame = 48'h77_00_00_00_00_7A;
      default:       frame = 48'h69_40_00_00_00_95;
    endcase
    return frame[8*(5-idx) +: 8];
  endfunction

  function automatic result_t send_byte(logic [7:0] b, logic sel);
    result_t r;
    r = '0;
    r.tx_byte = b;
    r.tx_valid = 1'b1;
    r.select_asserted = sel;
    return r;
  endfunction

  function automatic result_t end_sequence(logic [2:0] st);
    result_t r;
    r = '0;
    seq_phase = SeqDone;
    final_status = st;
    r.finished = 1'b1;
    r.status = st;
    return r;
  endfunction

  function automatic result_t begin_cmd(cmd_e c);
    cur_cmd = c;
    seq_phase = SeqCmd;
    byte_idx = 0;
    return send_byte(frame_byte(c, 0), 1'b1);
  endfunction

  // Works out the exchange that follows one request and advances the state.
  function automatic result_t next_exchange(logic kind, logic [7:0] rx, logic present);
    result_t r;
    logic    timed_out;
    r = '0;
    if (!kind) begin
      byte_idx = 0;
      poll_cnt = 0;
      retry_cnt = 0;
      last_r1 = 8'h00;
      ocr_byte = 8'h00;
      if (!present) begin
        r = end_sequence(StatusNoCard);
      end else begin
        seq_phase = SeqDummy;
        poll_cnt = 1;
        r = send_byte(IdleByte, 1'b0);
      end
      return r;
    end
    case (seq_phase)
      SeqDummy: begin
        if (poll_cnt < DummyBytesDefault) begin
          poll_cnt++;
          r = send_byte(IdleByte, 1'b0);
        end else begin
          r = begin_cmd(CmdGoIdle);
        end
      end
      SeqCmd: begin
        byte_idx++;
        if (byte_idx < CmdLen) begin
          r = send_byte(frame_byte(cur_cmd, byte_idx), 1'b1);
        end else begin
          seq_phase = SeqPoll;
          poll_cnt = 1;
          r = send_byte(IdleByte, 1'b1);
        end
      end
      SeqPoll: begin
        last_r1 = rx;
        timed_out = (rx == IdleByte);
        if (timed_out && poll_cnt < floor_one(poll_limit)) begin
          poll_cnt++;
          r = send_byte(IdleByte, 1'b1);
        end else begin
          // A response arrived, or the poll limit ran out.
          case (cur_cmd)
            CmdGoIdle: begin
              retry_cnt = 0;
              r = begin_cmd(CmdSendIfCond);
            end
            CmdSendIfCond: begin
              if (last_r1 == R1IdleState) begin
                r = begin_cmd(CmdReadOcr);
              end else begin
                retry_cnt++;
                if (retry_cnt >= floor_one(retry_limit)) r = end_sequence(StatusCmd8Timeout);
                else r = begin_cmd(CmdSendIfCond);
              end
            end
            CmdReadOcr: begin
              if (timed_out) begin
                ocr_byte = 8'h00;
                r = end_sequence(StatusVoltage);
              end else begin
                seq_phase = SeqOcr;
                byte_idx = 0;
                r = send_byte(IdleByte, 1'b1);
              end
            end
            CmdAppCmd: begin
              r = begin_cmd(CmdSdSendOpCond);
            end
            default: begin
              if (last_r1 == R1Ready) begin
                r = end_sequence(StatusOk);
              end else begin
                retry_cnt++;
                if (retry_cnt >= floor_one(retry_limit)) r = end_sequence(StatusAcmd41Timeout);
                else r = begin_cmd(CmdAppCmd);
              end
            end
          endcase
        end
      end
      SeqOcr: begin
        if (byte_idx == 1) ocr_byte = rx;
        byte_idx++;
        if (byte_idx < OcrBytes) begin
          r = send_byte(IdleByte, 1'b1);
        end else if (!ocr_byte[Vdd33Bit]) begin
          r = end_sequence(StatusVoltage);
        end else begin
          retry_cnt = 0;
          r = begin_cmd(CmdAppCmd);
        end
      end
      SeqDone: begin
        r.finished = 1'b1;
        r.status = final_status;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // Card model: picks the byte the card would have shifted back.
  function automatic logic [7:0] card_reply(int ff_pct, int fail_pct);
    logic [7:0] b;
    logic       miss;
    logic       coin;
    b = 8'($urandom);
    miss = ($urandom_range(0, 99) < fail_pct);
    coin = 1'($urandom);
    case (seq_phase)
      SeqPoll: begin
        if ($urandom_range(0, 99) < ff_pct) begin
          b = IdleByte;
        end else begin
          case (cur_cmd)
            CmdSendIfCond:   b = miss ? 8'($urandom_range(2, 254)) : R1IdleState;
            CmdSdSendOpCond: begin
              if (!miss) b = R1Ready;
              else b = coin ? R1IdleState : 8'($urandom_range(2, 254));
            end
            default:         b = coin ? R1IdleState : 8'($urandom_range(0, 254));
          endcase
        end
      end
      SeqOcr: if (byte_idx == 1) b[Vdd33Bit] = !miss;
      default: ;
    endcase
    return b;
  endfunction

  // Offers one request, records its expected exchange and waits for acceptance.
  task automatic send_request(logic kind, logic [7:0] rx, logic present);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    pending_exchanges.push_back(next_exchange(kind, rx, present));
    items_sent++;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'b0, present, rx};
    s_axis_tuser <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stops offering and waits until every expected exchange has come out.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_exchanges.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes both limit registers while the block is idle.
  task automatic retune(logic [7:0] polls, logic [7:0] retries);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgPollLimit;
    cfg_wdata_i <= polls;
    @(posedge clk_i);
    cfg_idx_i <= CfgRetryLimit;
    cfg_wdata_i <= retries;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    poll_limit = polls;
    retry_limit = retries;
  endtask

  // One start-up attempt against the card model, plus up to two bytes past the end.
  task automatic run_session(int ff_pct, int fail_pct, int noise_pct);
    logic present;
    present = ($urandom_range(0, 19) != 0);
    send_request(1'b0, 8'($urandom), present);
    while (seq_phase != SeqDone) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_request(1'($urandom), 8'($urandom), 1'($urandom));
      else
        send_request(1'b1, card_reply(ff_pct, fail_pct), 1'($urandom));
    end
    repeat ($urandom_range(0, 2)) send_request(1'b1, 8'($urandom), 1'($urandom));
  endtask

  function automatic logic [7:0] pick_limit();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return 8'($urandom_range(1, 6));
    if (sel == 7) return 8'd0;
    if (sel == 8) return 8'd255;
    return 8'($urandom);
  endfunction

  // Bytes while idle, a start with no card, and bytes after the end.
  task automatic test_idle_and_absent_card();
    send_request(1'b1, 8'h00, 1'b0);
    send_request(1'b1, 8'hFF, 1'b1);
    send_request(1'b0, 8'hFF, 1'b0);
    send_request(1'b1, 8'h00, 1'b1);
    send_request(1'b1, 8'hFF, 1'b0);
  endtask

  // A start in the middle of a sequence abandons it and begins anew.
  task automatic test_restart_midway();
    send_request(1'b0, 8'h00, 1'b1);
    send_request(1'b1, 8'hA5, 1'b0);
    send_request(1'b1, 8'h5A, 1'b1);
    send_request(1'b0, 8'hFF, 1'b1);
    repeat (3) send_request(1'b1, 8'hFF, 1'b0);
    send_request(1'b0, 8'h00, 1'b0);
    send_request(1'b1, 8'h01, 1'b1);
  endtask

  // Full sequences at the reset limits and at the extremes of both limits.
  task automatic test_limit_extremes();
    run_session(10, 20, 0);
    run_session(10, 20, 0);
    retune(8'd0, 8'd0);
    run_session(100, 0, 0);
    run_session(0, 100, 0);
    run_session(0, 0, 0);
    run_session(30, 50, 0);
    retune(8'd1, 8'd1);
    repeat (3) run_session(60, 30, 0);
    retune(8'd255, 8'd255);
    repeat (3) run_session(20, 30, 0);
    retune(8'd255, 8'd1);
    run_session(100, 0, 0);
    retune(8'd1, 8'd255);
    repeat (2) run_session(0, 60, 0);
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    retune(8'd4, 8'd4);
    idle_en <= 1'b0;
    hold_seq <= hold_seq + 1;
    // Enough requests to fill both registers while the receiver holds off.
    repeat (8) send_request(1'b1, 8'($urandom), 1'($urandom));
    run_session(10, 20, 0);
    idle_en <= 1'b1;
  endtask

  // Random limits and sessions with a little noise; no idling at the very end.
  task automatic test_random_sessions();
    int ff_pct;
    int fail_pct;
    while (items_sent < ItemTarget) begin
      if ($urandom_range(0, 3) == 0) retune(pick_limit(), pick_limit());
      if (retry_limit > 8 || poll_limit > 16) begin
        ff_pct = $urandom_range(0, 40);
        fail_pct = $urandom_range(0, 50);
      end else begin
        ff_pct = ($urandom_range(0, 4) == 0) ? 100 : $urandom_range(0, 90);
        fail_pct = $urandom_range(0, 100);
      end
      if (idle_en && items_sent > ItemTarget * 85 / 100) idle_en <= 1'b0;
      run_session(ff_pct, fail_pct, $urandom_range(0, 3));
    end
  endtask

  // Result checker and receiver stalls.
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_exchanges.size() == 0) begin
        $error("result with no pending exchange, tdata %h", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_exchanges.pop_front();
        if (m_axis_tdata[7:0] !== want.tx_byte) begin
          $error("tx_byte: expected %0h, got %0h", want.tx_byte, m_axis_tdata[7:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[8] !== want.tx_valid) begin
          $error("tx_valid: expected %0b, got %0b", want.tx_valid, m_axis_tdata[8]);
          mismatch_count++;
        end
        if (m_axis_tdata[9] !== want.select_asserted) begin
          $error("select_asserted: expected %0b, got %0b", want.select_asserted,
                 m_axis_tdata[9]);
          mismatch_count++;
        end
        if (m_axis_tdata[10] !== want.finished) begin
          $error("finished: expected %0b, got %0b", want.finished, m_axis_tdata[10]);
          mismatch_count++;
        end
        if (m_axis_tdata[13:11] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tdata[13:11]);
          mismatch_count++;
        end
      end
    end
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 4) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog on cycles in which neither side moves a request.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("FAIL sd_card_spi_init_sequencer");
        $finish;
      end
    end
  end

  initial begin
    seq_phase = SeqIdle;
    cur_cmd = CmdGoIdle;
    byte_idx = 0;
    poll_cnt = 0;
    retry_cnt = 0;
    last_r1 = 8'h00;
    ocr_byte = 8'h00;
    final_status = StatusOk;
    poll_limit = PollLimitReset;
    retry_limit = RetryLimitReset;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_idle_and_absent_card();
    test_restart_midway();
    test_limit_extremes();
    test_backpressure();
    test_random_sessions();
    drain();
    if (mismatch_count == 0) begin
      $display("PASS sd_card_spi_init_sequencer");
    end else begin
      $display("FAIL sd_card_spi_init_sequencer");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sdspi_pkg.sv
rtl/sdspi_fsm.sv
rtl/sd_card_spi_init_sequencer.sv
dv/sd_card_spi_init_sequencer_test.sv
